// ----- hw/rtl/cfs_pkg.sv -----
package cfs_pkg;

   localparam int LOC_W          = 12;
   localparam int CFS_LOCALS_MAX = 4095;
   localparam int BUDGET_W       = 16;

   localparam logic [BUDGET_W-1:0] CFS_RESET_BUDGET = 16'd32768;
   localparam logic [BUDGET_W-1:0] CFS_BYTES_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_PUSH        = 3'd0,
      OP_POP         = 3'd1,
      OP_FAST_POP    = 3'd2,
      OP_STEP        = 3'd3,
      OP_ADVANCE     = 3'd4,
      OP_JUMP        = 3'd5,
      OP_LOCAL_READ  = 3'd6,
      OP_LOCAL_WRITE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [31:0]      func_id;
      logic [31:0]      code_address;
      logic [LOC_W-1:0] new_locals;
      logic [15:0]      advance_by;
      logic [LOC_W-1:0] local_slot;
      logic [63:0]      write_value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [31:0]         pc_out;
      logic [31:0]         current_func;
      logic [LOC_W-1:0]    current_locals;
      logic [7:0]          frame_depth;
      logic [BUDGET_W-1:0] bytes_left;
      logic [63:0]         read_value;
   } rsp_type;

   typedef logic [BUDGET_W-1:0] cfg_type;

endpackage

// ----- hw/rtl/cfs_chan_if.sv -----
interface cfs_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/cfs_ram.sv -----
module cfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/cfs_cost.sv -----
module cfs_cost #(
   parameter int HEADER_BYTES = 32,
   parameter int VALUE_BYTES  = 8,
   parameter int ALIGN_BYTES  = 8,
   parameter int COST_W       =
      $clog2(HEADER_BYTES + cfs_pkg::CFS_LOCALS_MAX * VALUE_BYTES + ALIGN_BYTES)
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic [cfs_pkg::LOC_W-1:0] locals,
   output logic [COST_W-1:0]         cost
);

   import cfs_pkg::*;

   // Round up by reciprocal: floor(x * RECIP / 2^QSH) is exact for x below 2^COST_W
   localparam int SHIFT_L = $clog2(ALIGN_BYTES);
   localparam int QSH     = COST_W + SHIFT_L;
   localparam longint unsigned RECIP =
      ((64'd1 << QSH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
   localparam int PW = 2 * COST_W + 1;

   logic [COST_W-1:0] raw_ff;
   logic [PW-1:0]     prod_ff;
   logic [COST_W-1:0] quot;

   always_ff @(posedge clock) begin
      if (load) begin
         raw_ff <= COST_W'(locals) * COST_W'(VALUE_BYTES)
                   + COST_W'(HEADER_BYTES + ALIGN_BYTES - 1);
      end
      prod_ff <= PW'(raw_ff) * PW'(RECIP);
   end

   assign quot = COST_W'(prod_ff >> QSH);
   assign cost = quot * COST_W'(ALIGN_BYTES);

endmodule

// ----- hw/rtl/call_frame_stack_unit.sv -----
// Call-frame stack for a bytecode interpreter. The current frame (function, pc, locals
// count, locals base and its byte cost) lives in registers; caller frames sit in a frame
// memory indexed by depth, and all locals share one local memory. Each accepted request
// gives exactly one response, in order, through an output register, so the next request
// is taken while a response still waits for its transfer. Step, advance, jump, local
// read, local write and a pop at the base frame go straight to the emit step; a pop
// first does one frame-memory read; a push first passes the two-stage cost multiplier,
// the overflow check and the sweep that zeroes the new locals one word per cycle
// through the local memory's single write port. A write to the budget register
// restarts the stack at the base frame alone; neither memory needs a clearing pass,
// since every frame entry and every local is written before it can be read.
module call_frame_stack_unit #(
   parameter int MAX_FRAMES   = 256,
   parameter int LOCAL_WORDS  = 4096,
   parameter int HEADER_BYTES = 32,
   parameter int VALUE_BYTES  = 8,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic       clock,
   input  logic       reset,
   cfs_chan_if.sink   req_chan,
   cfs_chan_if.source rsp_chan,
   cfs_chan_if.sink   csr_chan
);

   import cfs_pkg::*;

   localparam int DW     = $clog2(MAX_FRAMES);
   localparam int LAW    = $clog2(LOCAL_WORDS);
   localparam int BW     = $clog2(LOCAL_WORDS + 1);
   localparam int SW     = ((BW > LOC_W) ? BW : LOC_W) + 2;
   localparam int COST_W = $clog2(HEADER_BYTES + CFS_LOCALS_MAX * VALUE_BYTES + ALIGN_BYTES);
   localparam int CMP_W  = ((COST_W > BUDGET_W) ? COST_W : BUDGET_W) + 1;
   localparam int BASE_COST = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_CHK   = 6'b000100,
      ST_CLEAR = 6'b001000,
      ST_POP   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic [31:0]       func;
      logic [31:0]       pc;
      logic [LOC_W-1:0]  count;
      logic [BW-1:0]     base;
      logic [COST_W-1:0] cost;
   } frame_type;

   function automatic logic [BUDGET_W-1:0] init_remaining(input logic [BUDGET_W-1:0] budget);
      init_remaining = (budget >= BUDGET_W'(BASE_COST)) ? budget - BUDGET_W'(BASE_COST) : '0;
   endfunction

   // sequencer and current frame
   state_type           state_ff,     state_in;
   logic [DW-1:0]       depth_ff,     depth_in;
   logic [31:0]         cur_pc_ff,    cur_pc_in;
   logic [31:0]         cur_func_ff,  cur_func_in;
   logic [LOC_W-1:0]    cur_count_ff, cur_count_in;
   logic [BW-1:0]       cur_base_ff,  cur_base_in;
   logic [COST_W-1:0]   cur_cost_ff,  cur_cost_in;
   logic [BUDGET_W-1:0] remain_ff,    remain_in;

   // request held while it is worked on
   op_type              op_ff,        op_in;
   logic [31:0]         func_ff,      func_in;
   logic [31:0]         addr_ff,      addr_in;
   logic [LOC_W-1:0]    nloc_ff,      nloc_in;
   status_type          status_ff,    status_in;
   logic [31:0]         old_pc_ff,    old_pc_in;
   logic [LOC_W-1:0]    clr_cnt_ff,   clr_cnt_in;

   // response register
   rsp_type             rsp_ff,       rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic                csr_accept;
   req_type             req;

   logic [COST_W-1:0]   push_cost;
   logic [SW-1:0]       nbase;
   logic [SW-1:0]       slot_idx;
   logic                slot_bad;
   logic                push_bad;
   logic [CMP_W-1:0]    back_bytes;

   logic                frm_we, frm_re;
   logic [DW-1:0]       frm_raddr;
   frame_type           frm_wdata, frm_rdata;

   logic                loc_we, loc_re;
   logic [LAW-1:0]      loc_waddr, loc_raddr;
   logic [63:0]         loc_wdata, loc_rdata;

   assign req            = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_accept     = csr_chan.valid & csr_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   cfs_cost #(
      .HEADER_BYTES (HEADER_BYTES),
      .VALUE_BYTES  (VALUE_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .COST_W       (COST_W)
   ) u_cost (
      .clock  (clock),
      .load   (req_accept),
      .locals (req.new_locals),
      .cost   (push_cost)
   );

   cfs_ram #(
      .WIDTH ($bits(frame_type)),
      .DEPTH (MAX_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frm_we),
      .wr_addr (depth_ff),
      .wr_data (frm_wdata),
      .rd_en   (frm_re),
      .rd_addr (frm_raddr),
      .rd_data (frm_rdata)
   );

   cfs_ram #(
      .WIDTH (64),
      .DEPTH (LOCAL_WORDS)
   ) u_local_ram (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (loc_waddr),
      .wr_data (loc_wdata),
      .rd_en   (loc_re),
      .rd_addr (loc_raddr),
      .rd_data (loc_rdata)
   );

   // new frame's locals start just past the current frame's
   assign nbase    = SW'(cur_base_ff) + SW'(cur_count_ff);
   assign slot_idx = SW'(cur_base_ff) + SW'(req.local_slot);
   assign slot_bad = (req.local_slot >= cur_count_ff) || (slot_idx >= SW'(LOCAL_WORDS));
   assign push_bad = (CMP_W'(push_cost) > CMP_W'(remain_ff))
                  || (depth_ff == DW'(MAX_FRAMES - 1))
                  || ((nbase + SW'(nloc_ff)) > SW'(LOCAL_WORDS));
   assign back_bytes = CMP_W'(remain_ff) + CMP_W'(cur_cost_ff);

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      cur_pc_in    = cur_pc_ff;
      cur_func_in  = cur_func_ff;
      cur_count_in = cur_count_ff;
      cur_base_in  = cur_base_ff;
      cur_cost_in  = cur_cost_ff;
      remain_in    = remain_ff;
      op_in        = op_ff;
      func_in      = func_ff;
      addr_in      = addr_ff;
      nloc_in      = nloc_ff;
      status_in    = status_ff;
      old_pc_in    = old_pc_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      frm_we    = 1'b0;
      frm_re    = 1'b0;
      frm_raddr = depth_ff - DW'(1);
      frm_wdata = '{func: cur_func_ff, pc: cur_pc_ff, count: cur_count_ff,
                    base: cur_base_ff, cost: cur_cost_ff};
      loc_we    = 1'b0;
      loc_re    = 1'b0;
      loc_raddr = LAW'(slot_idx);
      loc_waddr = LAW'(slot_idx);
      loc_wdata = req.write_value;

      // drop the response once its transfer completes
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req.op;
               func_in   = req.func_id;
               addr_in   = req.code_address;
               nloc_in   = req.new_locals;
               status_in = STATUS_OK;
               old_pc_in = cur_pc_ff;
               state_in  = ST_EMIT;
               case (req.op)
                  OP_PUSH: begin
                     state_in = ST_MUL;
                  end
                  OP_POP, OP_FAST_POP: begin
                     if (depth_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        frm_re   = 1'b1;
                        state_in = ST_POP;
                     end
                  end
                  OP_STEP: begin
                     cur_pc_in = cur_pc_ff + 32'd1;
                  end
                  OP_ADVANCE: begin
                     cur_pc_in = cur_pc_ff + 32'(req.advance_by);
                  end
                  OP_JUMP: begin
                     cur_pc_in = req.code_address;
                  end
                  OP_LOCAL_READ: begin
                     if (slot_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        loc_re = 1'b1;
                     end
                  end
                  OP_LOCAL_WRITE: begin
                     if (slot_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        loc_we = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (push_bad) begin
               status_in = STATUS_OVERFLOW;
               state_in  = ST_EMIT;
            end else begin
               // save the caller, then make the new frame current
               frm_we       = 1'b1;
               depth_in     = depth_ff + DW'(1);
               cur_func_in  = func_ff;
               cur_pc_in    = addr_ff;
               cur_count_in = nloc_ff;
               cur_base_in  = BW'(nbase);
               cur_cost_in  = push_cost;
               remain_in    = BUDGET_W'(CMP_W'(remain_ff) - CMP_W'(push_cost));
               clr_cnt_in   = '0;
               state_in     = (nloc_ff != '0) ? ST_CLEAR : ST_EMIT;
            end
         end
         ST_CLEAR: begin
            loc_we     = 1'b1;
            loc_waddr  = LAW'(SW'(cur_base_ff) + SW'(clr_cnt_ff));
            loc_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + LOC_W'(1);
            if (clr_cnt_ff == nloc_ff - LOC_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_POP: begin
            // resume the caller; the popped frame's cost goes back, saturating
            cur_func_in  = frm_rdata.func;
            cur_pc_in    = frm_rdata.pc;
            cur_count_in = frm_rdata.count;
            cur_base_in  = frm_rdata.base;
            cur_cost_in  = frm_rdata.cost;
            remain_in    = (back_bytes > CMP_W'(CFS_BYTES_MAX)) ? CFS_BYTES_MAX
                                                                : BUDGET_W'(back_bytes);
            depth_in     = depth_ff - DW'(1);
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.status         = status_ff;
               rsp_in.pc_out         = (op_ff == OP_JUMP) ? old_pc_ff : cur_pc_ff;
               rsp_in.current_func   = cur_func_ff;
               rsp_in.current_locals = cur_count_ff;
               rsp_in.frame_depth    = 8'(depth_ff);
               rsp_in.bytes_left     = remain_ff;
               rsp_in.read_value     = (op_ff == OP_LOCAL_READ && status_ff == STATUS_OK)
                                       ? loc_rdata : '0;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // budget write: restart with the base frame alone
      if (csr_accept) begin
         depth_in     = '0;
         cur_pc_in    = '0;
         cur_func_in  = '0;
         cur_count_in = '0;
         cur_base_in  = '0;
         cur_cost_in  = '0;
         remain_in    = init_remaining(csr_chan.payload);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         cur_pc_ff    <= '0;
         cur_func_ff  <= '0;
         cur_count_ff <= '0;
         cur_base_ff  <= '0;
         cur_cost_ff  <= '0;
         remain_ff    <= init_remaining(CFS_RESET_BUDGET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cur_pc_ff    <= cur_pc_in;
         cur_func_ff  <= cur_func_in;
         cur_count_ff <= cur_count_in;
         cur_base_ff  <= cur_base_in;
         cur_cost_ff  <= cur_cost_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      func_ff    <= func_in;
      addr_ff    <= addr_in;
      nloc_ff    <= nloc_in;
      status_ff  <= status_in;
      old_pc_ff  <= old_pc_in;
      clr_cnt_ff <= clr_cnt_in;
      rsp_ff     <= rsp_in;
   end

   // a successful push deepens the stack by exactly one frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && !push_bad && !csr_accept) |=> depth_ff == $past(depth_ff) + DW'(1))
      else $error("push did not advance depth by one");

   // the clearing sweep stays inside the new frame
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> (clr_cnt_ff < cur_count_ff && cur_count_ff == nloc_ff))
      else $error("local clear outside the new frame");

   // a pop never lowers the remaining budget
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && !csr_accept) |=> remain_ff >= $past(remain_ff))
      else $error("pop reduced the byte budget");

   // a response is raised only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");

endmodule

// ----- tb/sv/call_frame_stack_unit_checker.sv -----
module call_frame_stack_unit_checker #(
   parameter int MAX_FRAMES   = 256,
   parameter int LOCAL_WORDS  = 4096,
   parameter int HEADER_BYTES = 32,
   parameter int VALUE_BYTES  = 8,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cfs_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cfs_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  cfs_pkg::cfg_type csr_payload,
   output int               mismatches,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cfs_pkg::*;

   // Shadow of the frame stack; bases are kept wide, since a base can reach LOCAL_WORDS
   logic [31:0]   frame_func    [MAX_FRAMES];
   logic [31:0]   frame_resume  [MAX_FRAMES];
   int unsigned   frame_nlocals [MAX_FRAMES];
   int unsigned   frame_base    [MAX_FRAMES];
   logic [63:0]   local_words   [LOCAL_WORDS];
   logic [31:0]   pc_now;
   int unsigned   depth_now;
   logic [15:0]   budget_left;
   rsp_type       expected_reports [$];

   function automatic int unsigned frame_bytes(int unsigned nlocals);
      int unsigned raw;
      raw = HEADER_BYTES + nlocals * VALUE_BYTES;
      return ((raw + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   endfunction

   // Drop every frame but the base one and reload the budget
   function automatic void restart_stack(cfg_type budget);
      for (int i = 0; i < MAX_FRAMES; i++) begin
         frame_func[i]    = '0;
         frame_resume[i]  = '0;
         frame_nlocals[i] = 0;
         frame_base[i]    = 0;
      end
      for (int i = 0; i < LOCAL_WORDS; i++) local_words[i] = '0;
      pc_now      = '0;
      depth_now   = 0;
      budget_left = (budget >= frame_bytes(0)) ? 16'(budget - frame_bytes(0)) : '0;
   endfunction

   function automatic rsp_type apply_frame_op(req_type r);
      rsp_type     o;
      int unsigned d;
      int unsigned cost;
      int unsigned nbase;
      int unsigned back;
      int unsigned idx;
      logic [31:0] pc_report;
      logic [63:0] rval;
      o    = '0;
      rval = '0;
      d    = depth_now;
      o.status = STATUS_OK;
      case (r.op)
         OP_PUSH: begin
            cost  = frame_bytes(r.new_locals);
            nbase = frame_base[d] + frame_nlocals[d];
            if (cost > budget_left || d + 1 >= MAX_FRAMES ||
                nbase + r.new_locals > LOCAL_WORDS) begin
               o.status = STATUS_OVERFLOW;
            end else begin
               frame_resume[d] = pc_now;
               d++;
               frame_func[d]    = r.func_id;
               frame_nlocals[d] = r.new_locals;
               frame_base[d]    = nbase;
               frame_resume[d]  = r.code_address;
               for (int k = 0; k < r.new_locals; k++) local_words[nbase + k] = '0;
               pc_now      = r.code_address;
               budget_left = 16'(budget_left - cost);
               depth_now   = d;
            end
         end
         OP_POP, OP_FAST_POP: begin
            if (d == 0) begin
               o.status = STATUS_UNDERFLOW;
            end else begin
               back = budget_left + frame_bytes(frame_nlocals[d]);
               budget_left = (back > CFS_BYTES_MAX) ? CFS_BYTES_MAX : 16'(back);
               d--;
               pc_now    = frame_resume[d];
               depth_now = d;
            end
         end
         OP_STEP:    pc_now = pc_now + 32'd1;
         OP_ADVANCE: pc_now = pc_now + 32'(r.advance_by);
         OP_JUMP: ;
         default: begin
            idx = frame_base[d] + r.local_slot;
            if (r.local_slot >= frame_nlocals[d] || idx >= LOCAL_WORDS) begin
               o.status = STATUS_RANGE;
            end else if (r.op == OP_LOCAL_READ) begin
               rval = local_words[idx];
            end else begin
               local_words[idx] = r.write_value;
            end
         end
      endcase

      // A jump reports the pc it leaves and retargets the current frame
      pc_report = pc_now;
      if (r.op == OP_JUMP) begin
         pc_now          = r.code_address;
         frame_resume[d] = r.code_address;
      end

      o.pc_out         = pc_report;
      o.current_func   = frame_func[d];
      o.current_locals = LOC_W'(frame_nlocals[d]);
      o.frame_depth    = 8'(d);
      o.bytes_left     = budget_left;
      o.read_value     = rval;
      return o;
   endfunction

   function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         restart_stack(CFS_RESET_BUDGET);
         expected_reports.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, rsp_payload);
            end else begin
               want = expected_reports.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("pc_out", 64'(want.pc_out), 64'(rsp_payload.pc_out));
               check_field("current_func", 64'(want.current_func),
                           64'(rsp_payload.current_func));
               check_field("current_locals", 64'(want.current_locals),
                           64'(rsp_payload.current_locals));
               check_field("frame_depth", 64'(want.frame_depth),
                           64'(rsp_payload.frame_depth));
               check_field("bytes_left", 64'(want.bytes_left), 64'(rsp_payload.bytes_left));
               check_field("read_value", want.read_value, rsp_payload.read_value);
            end
         end
         if (csr_valid && csr_ready) restart_stack(csr_payload);
         if (req_valid && req_ready) expected_reports.push_back(apply_frame_op(req_payload));
      end
      pending = expected_reports.size();
   end

endmodule

// ----- tb/sv/call_frame_stack_unit_tb.sv -----
module call_frame_stack_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cfs_pkg::*;

   localparam int PHASES     = 6;
   localparam int HOLD_OFF   = 300;   // cycles the receiver refuses transfers under pressure
   localparam int DRAIN_WAIT = 20;

   // Per-phase budget and op mix of the random part; idling mode follows phase/2
   localparam cfg_type PHASE_BUDGET [PHASES] = '{16'd32768, 16'hFFFF, 16'd1024,
                                                 16'd0, 16'd20000, 16'hFFFF};
   localparam int PHASE_ITEMS [PHASES] = '{300, 500, 300, 100, 350, 400};
   localparam int PHASE_PUSH  [PHASES] = '{22, 60, 25, 25, 22, 25};
   localparam int PHASE_POP   [PHASES] = '{18, 5, 18, 20, 18, 18};
   localparam int PHASE_NLOC  [PHASES] = '{16, 2, 16, 16, 16, 16};
   localparam int PHASE_WIDE  [PHASES] = '{2, 0, 2, 2, 2, 2};

   logic clock;
   logic reset;
   int   mismatches;
   int   pending;
   int   sender_idle_pct   = 17;
   int   receiver_idle_pct = 69;
   bit   stall_request     = 1'b0;
   bit   stall_done        = 1'b0;

   cfs_chan_if #(.payload_type(req_type)) req_if ();
   cfs_chan_if #(.payload_type(rsp_type)) rsp_if ();
   cfs_chan_if #(.payload_type(cfg_type)) csr_if ();

   call_frame_stack_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   call_frame_stack_unit_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_payload (csr_if.payload),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run
   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // Fill every field with random bits, then fix the op
   function automatic req_type random_request(op_type op);
      req_type r;
      r.op           = op;
      r.func_id      = $urandom;
      r.code_address = $urandom;
      r.new_locals   = LOC_W'($urandom);
      r.advance_by   = 16'($urandom);
      r.local_slot   = LOC_W'($urandom);
      r.write_value  = {$urandom, $urandom};
      return r;
   endfunction

   // Mostly well-formed traffic: small frames and slots that usually hit a live local,
   // with a thin layer of wide frame sizes and wild slots as noise
   function automatic req_type shaped_request(int push_pct, int pop_pct, int nloc_max,
                                              int wide_pct);
      req_type r;
      op_type  op;
      int      roll;
      roll = $urandom_range(99);
      if (roll < push_pct) op = OP_PUSH;
      else if (roll < push_pct + pop_pct) op = $urandom_range(1) ? OP_POP : OP_FAST_POP;
      else op = op_type'($urandom_range(int'(OP_STEP), int'(OP_LOCAL_WRITE)));
      r = random_request(op);
      roll = $urandom_range(99);
      if (roll >= 4 * wide_pct) r.new_locals = LOC_W'($urandom_range(nloc_max));
      else if (roll >= wide_pct) r.new_locals = LOC_W'($urandom_range(255));
      if ($urandom_range(99) < 85) r.local_slot = LOC_W'($urandom_range(3));
      if ($urandom_range(1)) r.advance_by = 16'($urandom_range(15));
      return r;
   endfunction

   // Offer one item and hold it until the transfer; return on the following falling edge
   // with valid still high, so a back-to-back item never drops valid in between
   task automatic send_op(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic directed_op(op_type op, logic [LOC_W-1:0] nloc, logic [LOC_W-1:0] slot,
                              logic [15:0] adv, logic [31:0] addr, logic [63:0] wval);
      req_type r;
      r = random_request(op);
      r.new_locals   = nloc;
      r.local_slot   = slot;
      r.advance_by   = adv;
      r.code_address = addr;
      r.write_value  = wval;
      send_op(r);
   endtask

   // Write the budget only once every response is back, with the request side quiet
   task automatic write_budget(cfg_type value);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Receiver: random back-pressure, plus one long hold-off when asked, so the output
   // register fills and the block has to refuse requests
   initial begin : receiver
      int held;
      forever begin
         if (stall_request && !stall_done) begin
            for (held = 0; held < HOLD_OFF; held++) begin
               rsp_if.ready <= 1'b0;
               @(negedge clock);
            end
            stall_done = 1'b1;
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int p;
      int n;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset budget
      // Pops and local accesses at the bare base frame
      directed_op(OP_POP,         '0, '0, '0, '0, '0);
      directed_op(OP_FAST_POP,    '0, '0, '0, '0, '0);
      directed_op(OP_LOCAL_READ,  '0, '0, '0, '0, '0);
      directed_op(OP_LOCAL_WRITE, '0, 12'hFFF, '0, '0, '1);
      // Pc arithmetic, including wrap through the top of the address space
      directed_op(OP_STEP,        '0, '0, '0, '0, '0);
      directed_op(OP_ADVANCE,     '0, '0, 16'hFFFF, '0, '0);
      directed_op(OP_JUMP,        '0, '0, '0, 32'hFFFF_FFFF, '0);
      directed_op(OP_ADVANCE,     '0, '0, 16'hFFFF, '0, '0);
      directed_op(OP_JUMP,        '0, '0, '0, 32'hFFFF_FFFF, '0);
      directed_op(OP_STEP,        '0, '0, '0, '0, '0);
      // Largest frame does not fit the reset budget
      directed_op(OP_PUSH,        12'hFFF, '0, '0, 32'hFFFF_FFFF, '0);

      // Full budget: the largest frame fits, then the local store runs out
      write_budget(16'hFFFF);
      directed_op(OP_PUSH,        12'hFFF, '0, '0, 32'hFFFF_FFFF, '0);
      directed_op(OP_LOCAL_WRITE, '0, 12'hFFE, '0, '0, '1);
      directed_op(OP_LOCAL_READ,  '0, 12'hFFE, '0, '0, '0);
      directed_op(OP_LOCAL_READ,  '0, '0, '0, '0, '0);
      directed_op(OP_LOCAL_READ,  '0, 12'hFFF, '0, '0, '0);
      directed_op(OP_PUSH,        12'd2, '0, '0, '0, '0);
      directed_op(OP_PUSH,        12'd1, '0, '0, '0, '0);
      directed_op(OP_POP,         '0, '0, '0, '0, '0);
      directed_op(OP_FAST_POP,    '0, '0, '0, '0, '0);

      // Budget that takes exactly one one-local frame
      write_budget(16'd72);
      directed_op(OP_PUSH,        12'd1, '0, '0, 32'h1234_5678, '0);
      directed_op(OP_PUSH,        '0, '0, '0, '0, '0);
      directed_op(OP_POP,         '0, '0, '0, '0, '0);

      // Budget below the base frame header leaves nothing to spend
      write_budget(16'd31);
      directed_op(OP_STEP,        '0, '0, '0, '0, '0);
      directed_op(OP_PUSH,        '0, '0, '0, '0, '0);

      // Random part: two phases per idling mode, the last mode without idling
      for (p = 0; p < PHASES; p++) begin
         write_budget(PHASE_BUDGET[p]);
         case (p / 2)
            0: begin
               sender_idle_pct   = 17;
               receiver_idle_pct = 69;
            end
            1: begin
               sender_idle_pct   = 69;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         if (p == PHASES - 1) stall_request = 1'b1;
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            send_op(shaped_request(PHASE_PUSH[p], PHASE_POP[p], PHASE_NLOC[p],
                                   PHASE_WIDE[p]));
         end
      end

      // Drain, then give any stray response time to show up
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
